@@ hdl/grsf_pkg.sv @@
// ----------------------------------------------------------------------------
// grsf_pkg
// Shared constants and codes for the greedy rectangle sector former.
// ----------------------------------------------------------------------------
package grsf_pkg;

    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int CNT_W    = SIDE_W + 1;
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_START   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_FINISHED = 2'd1,
        ST_ERROR    = 2'd2,
        ST_UNUSED   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH     = 2'd0,
        REG_MAP_HEIGHT    = 2'd1,
        REG_TEXTURE_LIMIT = 2'd2,
        REG_SPARE         = 2'd3
    } reg_idx_t;

endpackage

@@ hdl/grsf_cmd_if.sv @@
// ----------------------------------------------------------------------------
// grsf_cmd_if
// Command channel: load cell, request rectangle, start scan.
// ----------------------------------------------------------------------------
interface grsf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] cell_height;
    logic [7:0] cell_texture;

    modport source (output valid, kind, cell_x, cell_y, cell_height, cell_texture,
                    input ready);
    modport sink   (input valid, kind, cell_x, cell_y, cell_height, cell_texture,
                    output ready);
endinterface

@@ hdl/grsf_res_if.sv @@
// ----------------------------------------------------------------------------
// grsf_res_if
// Result channel: one rectangle, finished or error record per transfer.
// ----------------------------------------------------------------------------
interface grsf_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] origin_x;
    logic [5:0] origin_row;
    logic [6:0] span_width;
    logic [6:0] span_height;
    logic [7:0] rect_texture;
    logic [7:0] top_height;

    modport source (output valid, status, origin_x, origin_row, span_width,
                    span_height, rect_texture, top_height, input ready);
    modport sink   (input valid, status, origin_x, origin_row, span_width,
                    span_height, rect_texture, top_height, output ready);
endinterface

@@ hdl/greedy_rectangle_sector_former.sv @@
// ----------------------------------------------------------------------------
// greedy_rectangle_sector_former
// Greedy raster-scan mesher: splits a cell grid into matching rectangles.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : valid/ready command channel. LOAD writes one cell (height, texture)
//          in one transfer. START clears the visited map and rewinds the scan.
//          REQUEST returns exactly one record on res.
//   res  : valid/ready result channel, one output register. FOUND gives a
//          rectangle, FINISHED ends the scan, ERROR flags a bad texture id
//          and halts the scan until the next START.
//   cfg  : write port (cfg_write, cfg_index, cfg_data) for map width, map
//          height and texture limit. Write only while the block is idle.
// Operation:
//   A REQUEST walks the grid through the cell and visited memories, one
//   access per cycle into registered read ports: it skips visited cells,
//   tries cells to the right, tests cells downward, marks the cells of the
//   rectangle, then emits. A halted request rereads the seed cell and
//   emits an error record.
// Reset / START:
//   Both run a clearing pass over every cell of the visited map; cmd.ready
//   is low meanwhile, cfg writes are still taken.
// Stall:
//   Loads are taken while a result waits on res; a finished request holds
//   in its emit step until the output register is free.
// ----------------------------------------------------------------------------
module greedy_rectangle_sector_former
    import grsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    grsf_cmd_if.sink              cmd,
    grsf_res_if.source            res,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SEEK, S_SEEK_CHK, S_RIGHT, S_RIGHT_CHK,
        S_DOWN, S_DOWN_CHK, S_MARK, S_HALT_CHK, S_EMIT
    } state_t;

    // storage
    logic [15:0] cell_mem [CELLS];   // {height, texture}
    logic        vis_mem  [CELLS];
    logic [15:0] cell_rd_reg;
    logic        vis_rd_reg;

    // configuration
    logic [6:0] map_width_reg, map_height_reg;
    logic [8:0] tex_limit_reg;
    logic [CNT_W-1:0] w_eff, h_eff;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  col_reg, col_next, row_reg, row_next;  // scan position / seed
    logic [CNT_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [CNT_W-1:0]  sw_reg, sw_next, sh_reg, sh_next;
    logic [7:0]        tex_reg, tex_next, ht_reg, ht_next;
    logic              halted_reg, halted_next;
    status_t           st_reg, st_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    logic              res_valid_reg, res_valid_next;
    status_t           res_status_reg, res_status_next;
    logic [5:0]        res_ox_reg, res_ox_next, res_oy_reg, res_oy_next;
    logic [6:0]        res_sw_reg, res_sw_next, res_sh_reg, res_sh_next;
    logic [7:0]        res_tex_reg, res_tex_next, res_ht_reg, res_ht_next;

    logic              cmd_xfer, res_xfer;
    logic [ADDR_W-1:0] rd_addr, vis_waddr;
    logic              vis_we, vis_wdata;
    logic [7:0]        rd_tex, rd_ht;
    logic              rd_match;
    logic              x_last;        // x is the rightmost column of the span
    logic              y_last;

    assign cmd_xfer = cmd.valid && cmd.ready;
    assign res_xfer = res.valid && res.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign w_eff = (map_width_reg  > 7'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(map_width_reg);
    assign h_eff = (map_height_reg > 7'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(map_height_reg);

    assign rd_ht    = cell_rd_reg[15:8];
    assign rd_tex   = cell_rd_reg[7:0];
    assign rd_match = (rd_ht == ht_reg) && (rd_tex == tex_reg);
    assign x_last   = ({1'b0, x_reg} + 8'd1) == ({1'b0, col_reg} + {1'b0, sw_reg});
    assign y_last   = ({1'b0, y_reg} + 8'd1) == ({1'b0, row_reg} + {1'b0, sh_reg});

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= 7'(MAX_SIDE);
            map_height_reg <= 7'(MAX_SIDE);
            tex_limit_reg  <= 9'd256;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MAP_WIDTH:     map_width_reg  <= cfg_data[6:0];
                REG_MAP_HEIGHT:    map_height_reg <= cfg_data[6:0];
                REG_TEXTURE_LIMIT: tex_limit_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // memory read address
    always_comb
    begin
        unique case (state_reg)
            S_RIGHT: rd_addr = {row_reg[SIDE_W-1:0], x_reg[SIDE_W-1:0]};
            S_DOWN:  rd_addr = {y_reg[SIDE_W-1:0], x_reg[SIDE_W-1:0]};
            default: rd_addr = {row_reg[SIDE_W-1:0], col_reg[SIDE_W-1:0]};
        endcase
    end

    assign vis_we    = (state_reg == S_CLEAR) || (state_reg == S_MARK);
    assign vis_wdata = (state_reg == S_MARK);
    assign vis_waddr = (state_reg == S_CLEAR) ? clr_reg
                     : {y_reg[SIDE_W-1:0], x_reg[SIDE_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd_xfer && kind_t'(cmd.kind) == KIND_LOAD)
            cell_mem[{cmd.cell_y, cmd.cell_x}] <= {cmd.cell_height, cmd.cell_texture};
        cell_rd_reg <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_waddr] <= vis_wdata;
        vis_rd_reg <= vis_mem[rd_addr];
    end

    // scan sequencer
    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        sw_next         = sw_reg;
        sh_next         = sh_reg;
        tex_next        = tex_reg;
        ht_next         = ht_reg;
        halted_next     = halted_reg;
        st_next         = st_reg;
        clr_next        = clr_reg;
        res_valid_next  = res_valid_reg && !res_xfer;
        res_status_next = res_status_reg;
        res_ox_next     = res_ox_reg;
        res_oy_next     = res_oy_reg;
        res_sw_next     = res_sw_reg;
        res_sh_next     = res_sh_reg;
        res_tex_next    = res_tex_reg;
        res_ht_next     = res_ht_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    unique case (kind_t'(cmd.kind))
                        KIND_REQUEST: state_next = halted_reg ? S_HALT_CHK : S_SEEK;
                        KIND_START:
                        begin
                            col_next    = '0;
                            row_next    = '0;
                            halted_next = 1'b0;
                            clr_next    = '0;
                            state_next  = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_HALT_CHK:
            begin
                tex_next   = rd_tex;
                ht_next    = rd_ht;
                st_next    = ST_ERROR;
                state_next = S_EMIT;
            end
            S_SEEK:
            begin
                if (row_reg >= h_eff)
                begin
                    st_next    = ST_FINISHED;
                    state_next = S_EMIT;
                end
                else if (col_reg >= w_eff)
                begin
                    col_next = '0;
                    row_next = row_reg + CNT_W'(1);
                end
                else
                    state_next = S_SEEK_CHK;
            end
            S_SEEK_CHK:
            begin
                if (vis_rd_reg)
                begin
                    col_next   = col_reg + CNT_W'(1);
                    state_next = S_SEEK;
                end
                else
                begin
                    tex_next = rd_tex;
                    ht_next  = rd_ht;
                    if ({1'b0, rd_tex} >= tex_limit_reg)
                    begin
                        halted_next = 1'b1;
                        st_next     = ST_ERROR;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        // seed matches itself
                        sw_next    = CNT_W'(1);
                        x_next     = col_reg + CNT_W'(1);
                        state_next = S_RIGHT;
                    end
                end
            end
            S_RIGHT:
            begin
                if (x_reg >= w_eff)
                begin
                    x_next     = col_reg;
                    y_next     = row_reg + CNT_W'(1);
                    sh_next    = CNT_W'(1);
                    state_next = S_DOWN;
                end
                else
                    state_next = S_RIGHT_CHK;
            end
            S_RIGHT_CHK:
            begin
                if (!vis_rd_reg && rd_match)
                begin
                    sw_next    = sw_reg + CNT_W'(1);
                    x_next     = x_reg + CNT_W'(1);
                    state_next = S_RIGHT;
                end
                else
                begin
                    x_next     = col_reg;
                    y_next     = row_reg + CNT_W'(1);
                    sh_next    = CNT_W'(1);
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                if (y_reg >= h_eff)
                begin
                    x_next     = col_reg;
                    y_next     = row_reg;
                    state_next = S_MARK;
                end
                else
                    state_next = S_DOWN_CHK;
            end
            S_DOWN_CHK:
            begin
                if (!rd_match)
                begin
                    x_next     = col_reg;
                    y_next     = row_reg;
                    state_next = S_MARK;
                end
                else if (x_last)
                begin
                    sh_next    = sh_reg + CNT_W'(1);
                    y_next     = y_reg + CNT_W'(1);
                    x_next     = col_reg;
                    state_next = S_DOWN;
                end
                else
                begin
                    x_next     = x_reg + CNT_W'(1);
                    state_next = S_DOWN;
                end
            end
            S_MARK:
            begin
                if (x_last)
                begin
                    x_next = col_reg;
                    y_next = y_reg + CNT_W'(1);
                    if (y_last)
                    begin
                        st_next    = ST_FOUND;
                        state_next = S_EMIT;
                    end
                end
                else
                    x_next = x_reg + CNT_W'(1);
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = st_reg;
                    unique case (st_reg)
                        ST_FOUND:
                        begin
                            res_ox_next  = col_reg[SIDE_W-1:0];
                            res_oy_next  = row_reg[SIDE_W-1:0];
                            res_sw_next  = 7'(sw_reg);
                            res_sh_next  = 7'(sh_reg);
                            res_tex_next = tex_reg;
                            res_ht_next  = ht_reg;
                        end
                        ST_ERROR:
                        begin
                            res_ox_next  = col_reg[SIDE_W-1:0];
                            res_oy_next  = row_reg[SIDE_W-1:0];
                            res_sw_next  = '0;
                            res_sh_next  = '0;
                            res_tex_next = tex_reg;
                            res_ht_next  = ht_reg;
                        end
                        default:
                        begin
                            res_ox_next  = '0;
                            res_oy_next  = '0;
                            res_sw_next  = '0;
                            res_sh_next  = '0;
                            res_tex_next = '0;
                            res_ht_next  = '0;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            st_reg        <= ST_FINISHED;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            halted_reg    <= halted_next;
            res_valid_reg <= res_valid_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        sw_reg         <= sw_next;
        sh_reg         <= sh_next;
        tex_reg        <= tex_next;
        ht_reg         <= ht_next;
        res_status_reg <= res_status_next;
        res_ox_reg     <= res_ox_next;
        res_oy_reg     <= res_oy_next;
        res_sw_reg     <= res_sw_next;
        res_sh_reg     <= res_sh_next;
        res_tex_reg    <= res_tex_next;
        res_ht_reg     <= res_ht_next;
    end

    assign res.valid        = res_valid_reg;
    assign res.status       = res_status_reg;
    assign res.origin_x     = res_ox_reg;
    assign res.origin_row   = res_oy_reg;
    assign res.span_width   = res_sw_reg;
    assign res.span_height  = res_sh_reg;
    assign res.rect_texture = res_tex_reg;
    assign res.top_height   = res_ht_reg;

    // checks
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_xfer && kind_t'(cmd.kind) == KIND_START) |=> !cmd.ready)
        else $error("START not followed by clearing pass");

    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit step");

    a_mark_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |->
            (x_reg >= col_reg) && (x_reg < w_eff) && (y_reg >= row_reg) && (y_reg < h_eff))
        else $error("mark outside rectangle");

    a_halt_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && halted_reg) |-> (st_reg == ST_ERROR))
        else $error("halted scan emits non-error");

endmodule
